### design/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types and constants of the JSON string unescaper: parser phases,
// queue words between the front and back ends, result kinds and error codes.
// ============================================================================
package jsu_pkg;

  // Default depth of the queue between the parser front end and the emitter.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STRING,
    PH_ESCAPE,
    PH_HIGH_HEX,
    PH_WANT_BSL,
    PH_WANT_U,
    PH_LOW_HEX
  } phase_t;

  // What one queue word asks the back end to do.
  typedef enum logic [1:0] {
    OP_BYTES,
    OP_CLOSE,
    OP_FAIL
  } op_t;

  // One queue word: all results caused by one input byte.
  typedef struct packed {
    op_t             op;
    logic [1:0]      count;   // number of bytes minus one
    logic [3:0][7:0] data;    // data[0] goes out first
    logic [3:0]      code;
  } entry_t;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
  localparam logic [3:0] ERR_CONTROL    = 4'd2;
  localparam logic [3:0] ERR_ESCAPE     = 4'd3;
  localparam logic [3:0] ERR_HEX        = 4'd4;
  localparam logic [3:0] ERR_UNP_HIGH   = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd6;
  localparam logic [3:0] ERR_UNP_LOW    = 4'd7;
  localparam logic [3:0] ERR_UTF8       = 4'd8;
  localparam logic [3:0] ERR_END        = 4'd9;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hd800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hdbff;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hdc00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hdfff;
  localparam logic [20:0] SUPPL_BASE    = 21'h10000;
  localparam logic [20:0] CP_MAX        = 21'h10ffff;

  localparam logic [7:0] LEAD2_MIN      = 8'hc2;
  localparam logic [7:0] LEAD2_MAX      = 8'hdf;
  localparam logic [7:0] LEAD3_MIN      = 8'he0;
  localparam logic [7:0] LEAD3_MAX      = 8'hef;
  localparam logic [7:0] LEAD4_MIN      = 8'hf0;
  localparam logic [7:0] LEAD4_MAX      = 8'hf4;
  localparam logic [7:0] CH_SPACE       = 8'h20;

endpackage

### design/jsu_in_if.sv
// ============================================================================
// jsu_in_if
// Raw byte channel: one byte of the string literal, or an end of input mark.
// ============================================================================
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### design/jsu_out_if.sv
// ============================================================================
// jsu_out_if
// Result channel: a decoded byte, a valid close or an error code.
// ============================================================================
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output result_kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input result_kind, input error_code,
                  input last, output ready);
endinterface

### design/json_string_unescape_core.sv
// ============================================================================
// json_string_unescape_core
// JSON string literal unescaper: resolves escapes and \u sequences to UTF-8
// and checks the emitted byte stream as UTF-8.
//
//   channel   dir  payload                                          word
//   raw       in   in_byte[7:0], end_of_input                       1 byte
//   decoded   out  out_byte[7:0], result_kind[1:0], error_code[3:0], last
//
// One raw word is taken every cycle while the queue has room; each result
// leaves in a cycle of its own, so an escape that expands to four bytes leaves
// as four results, absorbed by the QUEUE_DEPTH-word queue.
// The results of each raw word pass through the queue into the output register.
// Synchronous reset returns the parser to idle and empties the queue.
// Either side may stall without loss: raw.ready drops only when the queue is full.
// ============================================================================
module json_string_unescape_core #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    raw,
  jsu_out_if.source decoded
);
  import jsu_pkg::*;

  logic   push, full, pop, empty;
  entry_t wr_entry, head;

  jsu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

### design/jsu_front.sv
// ============================================================================
// jsu_front
// Parser front end: takes one raw byte per cycle while the queue has room,
// tracks escapes and \u sequences, and pushes one queue word per byte that causes any result.
// ============================================================================
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  jsu_in_if.sink          raw,
  input  logic            full,
  output logic            push,
  output jsu_pkg::entry_t entry
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Returns {ok, value} for one hexadecimal digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // UTF-8 form of a code point as a queue word of one to four bytes.
  function automatic entry_t cp_entry(input logic [20:0] cp);
    entry_t e;
    e = '0;
    e.op = OP_BYTES;
    if (cp <= 21'h7f) begin
      e.count   = 2'd0;
      e.data[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      e.count   = 2'd1;
      e.data[0] = {3'b110, cp[10:6]};
      e.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      e.count   = 2'd2;
      e.data[0] = {4'b1110, cp[15:12]};
      e.data[1] = {2'b10, cp[11:6]};
      e.data[2] = {2'b10, cp[5:0]};
    end else begin
      e.count   = 2'd3;
      e.data[0] = {5'b11110, cp[20:18]};
      e.data[1] = {2'b10, cp[17:12]};
      e.data[2] = {2'b10, cp[11:6]};
      e.data[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic entry_t fail_entry(input logic [3:0] code);
    entry_t e;
    e = '0;
    e.op   = OP_FAIL;
    e.code = code;
    return e;
  endfunction

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] high_unit, high_unit_next;
  logic [15:0] low_unit, low_unit_next;

  logic        take;
  logic [7:0]  b;
  logic [4:0]  digit;
  logic [15:0] high_shift, low_shift;
  logic        hex_done;
  logic        high_is_lead, high_is_trail, low_ok;
  logic        clear_state;
  logic [20:0] pair_cp;

  assign raw.ready     = !full;
  assign take          = raw.valid && raw.ready;
  assign b             = raw.in_byte;
  assign digit         = hex_digit(b);
  assign high_shift    = {high_unit[11:0], digit[3:0]};
  assign low_shift     = {low_unit[11:0], digit[3:0]};
  assign hex_done      = (hex_count == 2'd3);
  assign high_is_lead  = (high_shift >= HIGH_SURR_MIN) && (high_shift <= HIGH_SURR_MAX);
  assign high_is_trail = (high_shift >= LOW_SURR_MIN) && (high_shift <= LOW_SURR_MAX);
  assign low_ok        = (low_shift >= LOW_SURR_MIN) && (low_shift <= LOW_SURR_MAX);
  // Inside the high surrogate range the offset is just the low ten bits.
  assign pair_cp       = SUPPL_BASE + {1'b0, high_unit[9:0], low_shift[9:0]};

  always_comb begin
    phase_next = phase;
    if (take) begin
      if (raw.end_of_input) begin
        phase_next = PH_IDLE;
      end else begin
        case (phase)
          PH_IDLE: begin
            phase_next = (b == CH_QUOTE) ? PH_STRING : PH_IDLE;
          end
          PH_STRING: begin
            if (b == CH_QUOTE || b < CH_SPACE) phase_next = PH_IDLE;
            else if (b == CH_BSL) phase_next = PH_ESCAPE;
          end
          PH_ESCAPE: begin
            case (b)
              CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                phase_next = PH_STRING;
              end
              CH_U:    phase_next = PH_HIGH_HEX;
              default: phase_next = PH_IDLE;
            endcase
          end
          PH_HIGH_HEX: begin
            if (!digit[4]) phase_next = PH_IDLE;
            else if (hex_done) begin
              if (high_is_lead) phase_next = PH_WANT_BSL;
              else if (high_is_trail) phase_next = PH_IDLE;
              else phase_next = PH_STRING;
            end
          end
          PH_WANT_BSL: begin
            phase_next = (b == CH_BSL) ? PH_WANT_U : PH_IDLE;
          end
          PH_WANT_U: begin
            phase_next = (b == CH_U) ? PH_LOW_HEX : PH_IDLE;
          end
          PH_LOW_HEX: begin
            if (!digit[4]) phase_next = PH_IDLE;
            else if (hex_done) phase_next = low_ok ? PH_STRING : PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    push           = 1'b0;
    entry          = '0;
    clear_state    = 1'b0;
    hex_count_next = hex_count;
    high_unit_next = high_unit;
    low_unit_next  = low_unit;
    if (take) begin
      if (raw.end_of_input) begin
        push        = 1'b1;
        entry       = fail_entry(ERR_END);
        clear_state = 1'b1;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (b != CH_QUOTE) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_NO_QUOTE);
              clear_state = 1'b1;
            end
          end
          PH_STRING: begin
            if (b == CH_QUOTE) begin
              push        = 1'b1;
              entry.op    = OP_CLOSE;
              clear_state = 1'b1;
            end else if (b < CH_SPACE) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_CONTROL);
              clear_state = 1'b1;
            end else if (b != CH_BSL) begin
              push          = 1'b1;
              entry.data[0] = b;
            end
          end
          PH_ESCAPE: begin
            push = 1'b1;
            case (b)
              CH_QUOTE, CH_BSL, CH_SLASH: entry.data[0] = b;
              CH_B: entry.data[0] = 8'h08;
              CH_F: entry.data[0] = 8'h0c;
              CH_N: entry.data[0] = 8'h0a;
              CH_R: entry.data[0] = 8'h0d;
              CH_T: entry.data[0] = 8'h09;
              CH_U: begin
                push           = 1'b0;
                hex_count_next = 2'd0;
                high_unit_next = '0;
              end
              default: begin
                entry       = fail_entry(ERR_ESCAPE);
                clear_state = 1'b1;
              end
            endcase
          end
          PH_HIGH_HEX: begin
            if (!digit[4]) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_HEX);
              clear_state = 1'b1;
            end else begin
              high_unit_next = high_shift;
              hex_count_next = hex_count + 2'd1;
              if (hex_done && !high_is_lead) begin
                push = 1'b1;
                if (high_is_trail) begin
                  entry       = fail_entry(ERR_UNP_LOW);
                  clear_state = 1'b1;
                end else begin
                  entry = cp_entry({5'd0, high_shift});
                end
              end
            end
          end
          PH_WANT_BSL: begin
            if (b != CH_BSL) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_UNP_HIGH);
              clear_state = 1'b1;
            end
          end
          PH_WANT_U: begin
            if (b != CH_U) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_UNP_HIGH);
              clear_state = 1'b1;
            end else begin
              hex_count_next = 2'd0;
              low_unit_next  = '0;
            end
          end
          PH_LOW_HEX: begin
            if (!digit[4]) begin
              push        = 1'b1;
              entry       = fail_entry(ERR_HEX);
              clear_state = 1'b1;
            end else begin
              low_unit_next  = low_shift;
              hex_count_next = hex_count + 2'd1;
              if (hex_done) begin
                push = 1'b1;
                if (!low_ok) begin
                  entry       = fail_entry(ERR_BAD_LOW);
                  clear_state = 1'b1;
                end else begin
                  entry = cp_entry(pair_cp);
                end
              end
            end
          end
          default: clear_state = 1'b1;
        endcase
      end
      if (clear_state) begin
        hex_count_next = '0;
        high_unit_next = '0;
        low_unit_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hex_count <= '0;
      high_unit <= '0;
      low_unit  <= '0;
    end else begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      high_unit <= high_unit_next;
      low_unit  <= low_unit_next;
    end
  end

  a_end_fails: assert property (@(posedge clk) disable iff (rst)
    (take && raw.end_of_input) |-> (push && entry.op == OP_FAIL && entry.code == ERR_END))
    else $error("end of input did not raise the end error");

endmodule

### design/jsu_queue.sv
// ============================================================================
// jsu_queue
// Small first-in first-out buffer of queue words between front and back end.
// ============================================================================
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output jsu_pkg::entry_t head,
  output logic            empty
);
  import jsu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= advance(wr_ptr);
      if (pop)  rd_ptr <= advance(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

### design/jsu_back.sv
// ============================================================================
// jsu_back
// Emitter back end: while the output is not stalled, drains queue words one result
// per cycle into an output register; runs the streaming UTF-8 check over every emitted byte.
// ============================================================================
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  jsu_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  jsu_out_if.source       decoded
);
  import jsu_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic [1:0]  hold_kind;
  logic [3:0]  hold_code;
  logic        hold_last;

  logic [1:0]  idx, idx_next;
  logic [1:0]  utf8_pending, utf8_pending_next;
  logic [1:0]  utf8_length, utf8_length_next;
  logic [20:0] utf8_partial, utf8_partial_next;
  logic        utf8_bad, utf8_bad_next;

  logic        load;
  logic        terminal;
  logic [7:0]  cur;
  logic [7:0]  r_byte;
  logic [1:0]  r_kind;
  logic [3:0]  r_code;
  logic        r_last;

  assign load     = !empty && (!hold_valid || decoded.ready);
  assign terminal = (head.op != OP_BYTES);
  assign cur      = head.data[idx];
  assign pop      = load && r_last;

  assign decoded.valid       = hold_valid;
  assign decoded.out_byte    = hold_byte;
  assign decoded.result_kind = hold_kind;
  assign decoded.error_code  = hold_code;
  assign decoded.last        = hold_last;

  always_comb begin
    r_byte = '0;
    r_kind = KIND_ERROR;
    r_code = head.code;
    r_last = 1'b1;
    case (head.op)
      OP_BYTES: begin
        r_byte = cur;
        r_kind = KIND_BYTE;
        r_code = ERR_NONE;
        r_last = (idx == head.count);
      end
      OP_CLOSE: begin
        if (utf8_pending != 2'd0 || utf8_bad) begin
          r_code = ERR_UTF8;
        end else begin
          r_kind = KIND_CLOSED;
          r_code = ERR_NONE;
        end
      end
      OP_FAIL: r_kind = KIND_ERROR;
      default: r_kind = KIND_ERROR;
    endcase
  end

  // Streaming UTF-8 check; a close or an error starts it afresh.
  always_comb begin
    utf8_pending_next = utf8_pending;
    utf8_length_next  = utf8_length;
    utf8_partial_next = utf8_partial;
    utf8_bad_next     = utf8_bad;
    idx_next          = idx;
    if (load) begin
      idx_next = r_last ? 2'd0 : idx + 2'd1;
      if (terminal) begin
        utf8_pending_next = '0;
        utf8_length_next  = '0;
        utf8_partial_next = '0;
        utf8_bad_next     = 1'b0;
      end else if (!utf8_bad) begin
        if (utf8_pending != 2'd0) begin
          if (cur[7:6] != 2'b10) begin
            utf8_bad_next = 1'b1;
          end else begin
            utf8_partial_next = {utf8_partial[14:0], cur[5:0]};
            utf8_pending_next = utf8_pending - 2'd1;
            if (utf8_pending == 2'd1) begin
              if ((utf8_length == 2'd1 && utf8_partial_next < 21'h80) ||
                  (utf8_length == 2'd2 && utf8_partial_next < 21'h800) ||
                  (utf8_length == 2'd3 && utf8_partial_next < SUPPL_BASE) ||
                  (utf8_partial_next >= {5'd0, HIGH_SURR_MIN} &&
                   utf8_partial_next <= {5'd0, LOW_SURR_MAX}) ||
                  utf8_partial_next > CP_MAX) begin
                utf8_bad_next = 1'b1;
              end
            end
          end
        end else if (cur[7]) begin
          if (cur >= LEAD2_MIN && cur <= LEAD2_MAX) begin
            utf8_length_next  = 2'd1;
            utf8_pending_next = 2'd1;
            utf8_partial_next = {16'd0, cur[4:0]};
          end else if (cur >= LEAD3_MIN && cur <= LEAD3_MAX) begin
            utf8_length_next  = 2'd2;
            utf8_pending_next = 2'd2;
            utf8_partial_next = {17'd0, cur[3:0]};
          end else if (cur >= LEAD4_MIN && cur <= LEAD4_MAX) begin
            utf8_length_next  = 2'd3;
            utf8_pending_next = 2'd3;
            utf8_partial_next = {18'd0, cur[2:0]};
          end else begin
            utf8_bad_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte <= r_byte;
      hold_kind <= r_kind;
      hold_code <= r_code;
      hold_last <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      idx          <= '0;
      utf8_pending <= '0;
      utf8_length  <= '0;
      utf8_partial <= '0;
      utf8_bad     <= 1'b0;
    end else begin
      if (load) hold_valid <= 1'b1;
      else if (decoded.ready) hold_valid <= 1'b0;
      idx          <= idx_next;
      utf8_pending <= utf8_pending_next;
      utf8_length  <= utf8_length_next;
      utf8_partial <= utf8_partial_next;
      utf8_bad     <= utf8_bad_next;
    end
  end

  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> ((hold_kind == KIND_ERROR) == (hold_code != ERR_NONE)))
    else $error("error code disagrees with result kind");
  a_check_cleared: assert property (@(posedge clk) disable iff (rst)
    (load && terminal) |=> (utf8_pending == 2'd0 && !utf8_bad))
    else $error("UTF-8 check not cleared after end of string");
  a_index_in_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && head.op == OP_BYTES) |-> (idx <= head.count))
    else $error("byte index beyond queue word");

endmodule
